// ===== hdl/kpta_pkg.sv =====
// ----------------------------------------------------------------------------
// kpta_pkg - shared types and codes of the keyed page table allocator
// Operation codes, page kind codes, the page entry layout and sequencer states.
// ----------------------------------------------------------------------------
package kpta_pkg;

    localparam int OP_W    = 3;
    localparam int KEY_W   = 16;
    localparam int LEN_W   = 7;
    localparam int PTYPE_W = 2;
    localparam int PIDX_W  = 6;
    localparam int KIND_W  = 3;

    localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLAIM     = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE_RESV = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

    localparam logic [KIND_W-1:0] KIND_FREE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  owner;
    } page_entry_t;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_FETCH    = 9'b000000100,
        ST_FIND     = 9'b000001000,
        ST_RUN      = 9'b000010000,
        ST_ROLLBACK = 9'b000100000,
        ST_CLAIM    = 9'b001000000,
        ST_FREE     = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

endpackage

// ===== hdl/kpta_page_mem.sv =====
// ----------------------------------------------------------------------------
// kpta_page_mem - page table store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kpta_page_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        wr_addr,
    input  kpta_pkg::page_entry_t wr_data,
    input  logic [AW-1:0]        rd_addr,
    output kpta_pkg::page_entry_t rd_data
);

    kpta_pkg::page_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/keyed_page_table_allocator.sv =====
// ----------------------------------------------------------------------------
// keyed_page_table_allocator - keyed page table with run allocation
// Allocates runs of pages for an owner key, claims, frees and queries pages.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel, one item per operation; every item
//   produces exactly one result item on the m_ channel.
//   A single sequencer walks the page store one entry per cycle through one
//   read and one write port. Alloc and claim scan from page 0; alloc then
//   reserves the rest of the run and on a blocked run sweeps back over the
//   reserved pages. Free scans from page_index up to the last page, query
//   reads page_index only; the longest operation is an alloc blocked at the
//   last page. s_tready is high only while the sequencer is idle.
//   After reset the store is cleared one page a cycle, with s_tready low.
//   A result waits in the output register while m_tready is low; the next
//   item is still accepted and worked on, and its result is held until the
//   output register frees up.
// ----------------------------------------------------------------------------
module keyed_page_table_allocator #(
    parameter int PAGE_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], key[18:3], run_length[25:19], page_type[27:26], page_index[33:28]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], result_index[6:1], result_type[9:7]
    output logic [15:0] m_tdata
);

    localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int SW = $clog2(PAGE_COUNT + 128) + 1;
    localparam logic [AW-1:0] LAST = AW'(PAGE_COUNT - 1);

    logic [kpta_pkg::OP_W-1:0]    in_op;
    logic [kpta_pkg::KEY_W-1:0]   in_key;
    logic [kpta_pkg::LEN_W-1:0]   in_len;
    logic [kpta_pkg::PTYPE_W-1:0] in_type;
    logic [kpta_pkg::PIDX_W-1:0]  in_index;

    assign in_op    = s_tdata[2:0];
    assign in_key   = s_tdata[18:3];
    assign in_len   = s_tdata[25:19];
    assign in_type  = s_tdata[27:26];
    assign in_index = s_tdata[33:28];

    kpta_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    beg_reg, beg_next;
    logic [AW-1:0]    stop_reg, stop_next;
    logic [kpta_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [kpta_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [kpta_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [kpta_pkg::PTYPE_W-1:0] type_reg, type_next;
    logic [kpta_pkg::OP_W-1:0]    op_reg, op_next;

    logic                         res_ok_reg, res_ok_next;
    logic [kpta_pkg::PIDX_W-1:0]  res_index_reg, res_index_next;
    logic [kpta_pkg::KIND_W-1:0]  res_type_reg, res_type_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic                  mem_we;
    kpta_pkg::page_entry_t mem_wdata;
    kpta_pkg::page_entry_t mem_rdata;
    logic                  in_range;
    logic                  accept;
    logic                  run_overflows;

    kpta_page_mem #(
        .DEPTH (PAGE_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (addr_reg),
        .wr_data (mem_wdata),
        .rd_addr (addr_next),
        .rd_data (mem_rdata)
    );

    assign s_tready = (state_reg == kpta_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = int'(in_index) < PAGE_COUNT;
    assign run_overflows = (SW'(addr_reg) + SW'(len_reg)) > SW'(PAGE_COUNT);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        beg_next       = beg_reg;
        stop_next      = stop_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        key_next       = key_reg;
        type_next      = type_reg;
        op_next        = op_reg;
        res_ok_next    = res_ok_reg;
        res_index_next = res_index_reg;
        res_type_next  = res_type_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_wdata      = '{kind: kpta_pkg::KIND_FREE, owner: '0};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            kpta_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == LAST)
                begin
                    addr_next  = '0;
                    state_next = kpta_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            kpta_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = in_op;
                    key_next       = in_key;
                    len_next       = in_len;
                    type_next      = in_type;
                    res_ok_next    = 1'b0;
                    res_index_next = '0;
                    res_type_next  = '0;
                    case (in_op)
                        kpta_pkg::OP_ALLOC:
                        begin
                            addr_next  = '0;
                            state_next = kpta_pkg::ST_FIND;
                        end
                        kpta_pkg::OP_CLAIM:
                        begin
                            addr_next  = '0;
                            state_next = kpta_pkg::ST_CLAIM;
                        end
                        kpta_pkg::OP_FREE, kpta_pkg::OP_FREE_RESV, kpta_pkg::OP_QUERY:
                        begin
                            if (in_range)
                            begin
                                addr_next  = AW'(in_index);
                                state_next = kpta_pkg::ST_FETCH;
                            end
                            else
                            begin
                                state_next = kpta_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = kpta_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            kpta_pkg::ST_FETCH:
            begin
                // data of the start page is in; reread it for the free scan
                if (op_reg == kpta_pkg::OP_QUERY)
                begin
                    res_ok_next   = 1'b1;
                    res_type_next = mem_rdata.kind;
                    state_next    = kpta_pkg::ST_DONE;
                end
                else
                begin
                    key_next   = mem_rdata.owner;
                    state_next = kpta_pkg::ST_FREE;
                end
            end

            kpta_pkg::ST_FIND:
            begin
                if (mem_rdata.kind == kpta_pkg::KIND_FREE)
                begin
                    mem_we   = 1'b1;
                    beg_next = addr_reg;
                    if (run_overflows)
                    begin
                        // owner stays written, page stays free
                        mem_wdata  = '{kind: kpta_pkg::KIND_FREE, owner: key_reg};
                        state_next = kpta_pkg::ST_DONE;
                    end
                    else
                    begin
                        mem_wdata = '{kind: kpta_pkg::KIND_RESERVED, owner: key_reg};
                        if (len_reg <= kpta_pkg::LEN_W'(1))
                        begin
                            res_ok_next    = 1'b1;
                            res_index_next = kpta_pkg::PIDX_W'(addr_reg);
                            state_next     = kpta_pkg::ST_DONE;
                        end
                        else
                        begin
                            rem_next   = len_reg - 1'b1;
                            addr_next  = addr_reg + 1'b1;
                            state_next = kpta_pkg::ST_RUN;
                        end
                    end
                end
                else if (addr_reg == LAST)
                begin
                    state_next = kpta_pkg::ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            kpta_pkg::ST_RUN:
            begin
                if (mem_rdata.kind != kpta_pkg::KIND_FREE)
                begin
                    // blocked: sweep back over the pages reserved so far
                    stop_next  = addr_reg;
                    addr_next  = beg_reg;
                    state_next = kpta_pkg::ST_ROLLBACK;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{kind: kpta_pkg::KIND_RESERVED, owner: key_reg};
                    if (rem_reg == kpta_pkg::LEN_W'(1))
                    begin
                        res_ok_next    = 1'b1;
                        res_index_next = kpta_pkg::PIDX_W'(beg_reg);
                        state_next     = kpta_pkg::ST_DONE;
                    end
                    else
                    begin
                        rem_next  = rem_reg - 1'b1;
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end

            kpta_pkg::ST_ROLLBACK:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{kind: kpta_pkg::KIND_FREE, owner: key_reg};
                if (addr_reg + 1'b1 == stop_reg)
                begin
                    state_next = kpta_pkg::ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            kpta_pkg::ST_CLAIM:
            begin
                if (mem_rdata.owner == key_reg && mem_rdata.kind == kpta_pkg::KIND_RESERVED)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = '{kind: {1'b0, type_reg}, owner: mem_rdata.owner};
                    res_ok_next    = 1'b1;
                    res_index_next = kpta_pkg::PIDX_W'(addr_reg);
                    state_next     = kpta_pkg::ST_DONE;
                end
                else if (addr_reg == LAST)
                begin
                    state_next = kpta_pkg::ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            kpta_pkg::ST_FREE:
            begin
                if (mem_rdata.owner == key_reg &&
                    (op_reg != kpta_pkg::OP_FREE_RESV ||
                     mem_rdata.kind == kpta_pkg::KIND_RESERVED))
                begin
                    mem_we = 1'b1;
                end
                if (addr_reg == LAST)
                begin
                    res_ok_next = 1'b1;
                    state_next  = kpta_pkg::ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            kpta_pkg::ST_DONE:
            begin
                // hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, res_type_reg, res_index_reg, res_ok_reg};
                    state_next    = kpta_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kpta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kpta_pkg::ST_CLEAR;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beg_reg       <= beg_next;
        stop_reg      <= stop_next;
        rem_reg       <= rem_next;
        len_reg       <= len_next;
        key_reg       <= key_next;
        type_reg      <= type_next;
        op_reg        <= op_next;
        res_ok_reg    <= res_ok_next;
        res_index_reg <= res_index_next;
        res_type_reg  <= res_type_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

// ===== bench/tb_keyed_page_table_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_page_table_allocator - self-checking bench for the page allocator
// Walks a short table of directed requests, then random request mixes over
// four idling modes, and checks every result item against a shadow page table or a row's fixed expectation.
// ----------------------------------------------------------------------------
module tb_keyed_page_table_allocator;

    localparam int PAGES          = 64;
    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int ITEMS_PER_MODE = 282;

    localparam logic [kpta_pkg::OP_W-1:0] OP_BAD_FIRST = 3'd5;
    localparam logic [kpta_pkg::OP_W-1:0] OP_BAD_LAST  = 3'd7;

    // request fields, op in the lowest bits
    typedef struct packed {
        logic [kpta_pkg::PIDX_W-1:0]  index;
        logic [kpta_pkg::PTYPE_W-1:0] ptype;
        logic [kpta_pkg::LEN_W-1:0]   len;
        logic [kpta_pkg::KEY_W-1:0]   key;
        logic [kpta_pkg::OP_W-1:0]    op;
    } page_req_t;

    // result fields, ok in the lowest bit
    typedef struct packed {
        logic [kpta_pkg::KIND_W-1:0] rtype;
        logic [kpta_pkg::PIDX_W-1:0] index;
        logic                        ok;
    } page_res_t;

    typedef struct {
        page_req_t req;
        bit        typed;
        page_res_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [kpta_pkg::KIND_W-1:0] shadow_kind [PAGES];
    logic [kpta_pkg::KEY_W-1:0]  shadow_owner[PAGES];

    page_res_t     pending_results[$];
    directed_row_t directed_rows[$];

    int  tx_pct = 0;
    int  rx_pct = 0;
    bit  hold_req = 1'b0;
    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_alloc_ok = 0;
    int  n_claim_ok = 0;
    int  quiet_cycles = 0;
    page_res_t mon_want, mon_got;

    int tx_modes[4] = '{0, 53, 0, 31};
    int rx_modes[4] = '{0, 0, 53, 31};

    keyed_page_table_allocator #(.PAGE_COUNT(PAGES)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Shadow of the page table: apply one request, return its result.
    function automatic page_res_t predict_page_op(page_req_t r);
        page_res_t                  o;
        int                         beg;
        int                         i;
        int                         j;
        bit                         run_ok;
        logic [kpta_pkg::KEY_W-1:0] match_key;
        o = '0;
        case (r.op)
            kpta_pkg::OP_ALLOC:
            begin
                beg = PAGES;
                for (i = 0; i < PAGES; i++)
                begin
                    if (shadow_kind[i] == kpta_pkg::KIND_FREE)
                    begin
                        beg = i;
                        break;
                    end
                end
                if (beg < PAGES)
                begin
                    // owner is written before the fit check and stays on failure
                    shadow_owner[beg] = r.key;
                    shadow_kind[beg]  = kpta_pkg::KIND_RESERVED;
                    if (beg + int'(r.len) > PAGES)
                        shadow_kind[beg] = kpta_pkg::KIND_FREE;
                    else
                    begin
                        run_ok = 1'b1;
                        for (i = beg + 1; i < beg + int'(r.len); i++)
                        begin
                            if (shadow_kind[i] != kpta_pkg::KIND_FREE)
                            begin
                                for (j = beg; j < i; j++)
                                    shadow_kind[j] = kpta_pkg::KIND_FREE;
                                run_ok = 1'b0;
                                break;
                            end
                            shadow_owner[i] = r.key;
                            shadow_kind[i]  = kpta_pkg::KIND_RESERVED;
                        end
                        if (run_ok)
                        begin
                            o.ok    = 1'b1;
                            o.index = beg[kpta_pkg::PIDX_W-1:0];
                        end
                    end
                end
            end
            kpta_pkg::OP_CLAIM:
            begin
                for (i = 0; i < PAGES; i++)
                begin
                    if (shadow_owner[i] == r.key &&
                        shadow_kind[i] == kpta_pkg::KIND_RESERVED)
                    begin
                        shadow_kind[i] = {1'b0, r.ptype};
                        o.ok    = 1'b1;
                        o.index = i[kpta_pkg::PIDX_W-1:0];
                        break;
                    end
                end
            end
            kpta_pkg::OP_FREE, kpta_pkg::OP_FREE_RESV:
            begin
                match_key = shadow_owner[r.index];
                for (i = int'(r.index); i < PAGES; i++)
                begin
                    if (shadow_owner[i] == match_key &&
                        (r.op == kpta_pkg::OP_FREE ||
                         shadow_kind[i] == kpta_pkg::KIND_RESERVED))
                    begin
                        shadow_owner[i] = '0;
                        shadow_kind[i]  = kpta_pkg::KIND_FREE;
                    end
                end
                o.ok = 1'b1;
            end
            kpta_pkg::OP_QUERY:
            begin
                o.ok    = 1'b1;
                o.rtype = shadow_kind[r.index];
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [kpta_pkg::KEY_W-1:0] random_key();
        int p;
        p = $urandom_range(99);
        if (p < 80)
            return kpta_pkg::KEY_W'($urandom_range(6, 1));
        else if (p < 90)
            return '0;
        return kpta_pkg::KEY_W'($urandom);
    endfunction

    // Mostly meaningful requests: keys from a small pool, indexes on pages in use.
    function automatic page_req_t random_page_op();
        page_req_t r;
        int        p;
        int        start;
        int        i;
        int        pg;
        p = $urandom_range(99);
        if (p < 30)
            r.op = kpta_pkg::OP_ALLOC;
        else if (p < 50)
            r.op = kpta_pkg::OP_CLAIM;
        else if (p < 65)
            r.op = kpta_pkg::OP_FREE;
        else if (p < 75)
            r.op = kpta_pkg::OP_FREE_RESV;
        else if (p < 95)
            r.op = kpta_pkg::OP_QUERY;
        else
            r.op = kpta_pkg::OP_W'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
        r.key = random_key();
        p = $urandom_range(99);
        if (p < 75)
            r.len = kpta_pkg::LEN_W'($urandom_range(6, 1));
        else if (p < 92)
            r.len = kpta_pkg::LEN_W'($urandom_range(PAGES, 7));
        else
            r.len = kpta_pkg::LEN_W'($urandom_range(127));
        r.ptype = ($urandom_range(9) == 0) ? kpta_pkg::PTYPE_W'(0)
                                           : kpta_pkg::PTYPE_W'($urandom_range(3, 1));
        r.index = kpta_pkg::PIDX_W'($urandom_range(PAGES - 1));
        start = $urandom_range(PAGES - 1);
        if ($urandom_range(99) < 60)
        begin
            for (i = 0; i < PAGES; i++)
            begin
                pg = (start + i) % PAGES;
                if (r.op == kpta_pkg::OP_CLAIM &&
                    shadow_kind[pg] == kpta_pkg::KIND_RESERVED)
                begin
                    r.key = shadow_owner[pg];
                    break;
                end
                if (r.op != kpta_pkg::OP_CLAIM && shadow_kind[pg] != kpta_pkg::KIND_FREE)
                begin
                    r.index = pg[kpta_pkg::PIDX_W-1:0];
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic [kpta_pkg::OP_W-1:0] op,
                           input logic [kpta_pkg::KEY_W-1:0] key,
                           input int len, input int ptype, input int index,
                           input bit typed, input bit ok, input int ridx,
                           input logic [kpta_pkg::KIND_W-1:0] rtype);
        directed_row_t row;
        row.req.op     = op;
        row.req.key    = key;
        row.req.len    = kpta_pkg::LEN_W'(len);
        row.req.ptype  = kpta_pkg::PTYPE_W'(ptype);
        row.req.index  = kpta_pkg::PIDX_W'(index);
        row.typed      = typed;
        row.want.ok    = ok;
        row.want.index = kpta_pkg::PIDX_W'(ridx);
        row.want.rtype = rtype;
        directed_rows.push_back(row);
    endtask

    task automatic send_page_op(input page_req_t r, input bit typed, input page_res_t want);
        int        gap;
        page_res_t pred;
        gap = 0;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct)
            gap++;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_page_op(r);
        pending_results.push_back(typed ? want : pred);
        n_items++;
        if (r.op == kpta_pkg::OP_ALLOC && pred.ok)
            n_alloc_ok++;
        if (r.op == kpta_pkg::OP_CLAIM && pred.ok)
            n_claim_ok++;
    endtask

    // drop the request line so the last item is not offered again
    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: m_tdata=%h", m_tdata);
                errors++;
            end
            else
            begin
                mon_want = pending_results.pop_front();
                mon_got  = page_res_t'(m_tdata[9:0]);
                if (mon_got.ok !== mon_want.ok)
                begin
                    $error("ok: expected %0d, got %0d", mon_want.ok, mon_got.ok);
                    errors++;
                end
                if (mon_got.index !== mon_want.index)
                begin
                    $error("result_index: expected %0d, got %0d",
                           mon_want.index, mon_got.index);
                    errors++;
                end
                if (mon_got.rtype !== mon_want.rtype)
                begin
                    $error("result_type: expected %0d, got %0d",
                           mon_want.rtype, mon_got.rtype);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int        m;
        int        k;
        page_res_t none;
        none = '0;
        for (k = 0; k < PAGES; k++)
        begin
            shadow_kind[k]  = kpta_pkg::KIND_FREE;
            shadow_owner[k] = '0;
        end

        // table cleared at reset
        add_row(kpta_pkg::OP_QUERY,     16'h0000,   1, 1,  0, 1, 1, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_QUERY,     16'h0000,   1, 1, 63, 1, 1, 0, kpta_pkg::KIND_FREE);
        // zero run length reserves only the first free page
        add_row(kpta_pkg::OP_ALLOC,     16'hFFFF,   0, 0,  0, 1, 1, 0, kpta_pkg::KIND_FREE);
        // run does not fit past the end of the table
        add_row(kpta_pkg::OP_ALLOC,     16'h0000,  64, 2,  5, 1, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_ALLOC,     16'h0001,  63, 1,  0, 0, 0, 0, kpta_pkg::KIND_FREE);
        // table full: no free page
        add_row(kpta_pkg::OP_ALLOC,     16'h0002,   1, 1,  0, 1, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_QUERY,     16'h0000,   1, 1, 63, 1, 1, 0,
                kpta_pkg::KIND_RESERVED);
        add_row(kpta_pkg::OP_CLAIM,     16'h0001,   1, 3,  0, 0, 0, 0, kpta_pkg::KIND_FREE);
        // no reserved page for this key
        add_row(kpta_pkg::OP_CLAIM,     16'h1234,   1, 1,  0, 1, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_FREE_RESV, 16'h0000,   1, 1,  2, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_QUERY,     16'h0000,   1, 1,  1, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_FREE,      16'h0000,   1, 1,  1, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_ALLOC,     16'h0005, 127, 1,  0, 1, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_ALLOC,     16'h0005,   3, 1,  0, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_ALLOC,     16'h0006,   2, 1,  0, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_FREE,      16'h0000,   1, 1,  2, 0, 0, 0, kpta_pkg::KIND_FREE);
        // run blocked by a reserved page: roll back
        add_row(kpta_pkg::OP_ALLOC,     16'h0007,   3, 1,  0, 1, 0, 0, kpta_pkg::KIND_FREE);
        // claim with type zero frees the page but keeps its owner
        add_row(kpta_pkg::OP_CLAIM,     16'h0006,   1, 0,  0, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_CLAIM,     16'h0006,   1, 2,  0, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_QUERY,     16'h0000,   1, 1,  5, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(OP_BAD_FIRST,           16'hFFFF, 127, 3, 63, 1, 0, 0, kpta_pkg::KIND_FREE);
        add_row(OP_BAD_LAST,            16'h0000,   0, 0,  0, 1, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_QUERY,     16'h0000,   1, 1,  4, 0, 0, 0, kpta_pkg::KIND_FREE);
        // free on a page already free
        add_row(kpta_pkg::OP_FREE,      16'h0000,   1, 1, 63, 0, 0, 0, kpta_pkg::KIND_FREE);
        add_row(kpta_pkg::OP_FREE_RESV, 16'h0000,   1, 1,  0, 0, 0, 0, kpta_pkg::KIND_FREE);

        @(posedge rst_n);
        for (k = 0; k < directed_rows.size(); k++)
            send_page_op(directed_rows[k].req, directed_rows[k].typed,
                         directed_rows[k].want);

        for (m = 0; m < 4; m++)
        begin
            tx_pct = tx_modes[m];
            rx_pct = rx_modes[m];
            for (k = 0; k < ITEMS_PER_MODE; k++)
            begin
                // hold the output long enough that the input backs up
                if (m == 0 && k == 100)
                    hold_req = 1'b1;
                // pause until every outstanding result is back
                if (m == 2 && k == 140)
                    wait_results_drained();
                send_page_op(random_page_op(), 1'b0, none);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        rx_pct = 0;
        wait_results_drained();
        repeat (2 * PAGES + 8) @(posedge clk);

        $display("covered %0d requests and %0d results (%0d allocs, %0d claims granted)",
                 n_items, n_results, n_alloc_ok, n_claim_ok);
        $display("four idling modes, one long output hold-off, one drain pause");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kpta_pkg.sv
hdl/kpta_page_mem.sv
hdl/keyed_page_table_allocator.sv
bench/tb_keyed_page_table_allocator.sv
